FILE: rtl/core/xec_pkg.sv
// xec_pkg: payload types, work descriptor and entity tables for the entity codec
// no dependencies
package xec_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_t;

  localparam int unsigned JobBytes = 5;
  localparam int unsigned HoldMax  = 4;
  localparam int unsigned NumEnt   = 4;

  typedef logic [2:0] job_cnt_t;

  // up to five output bytes produced by one request, in emission order
  typedef struct packed {
    logic [JobBytes-1:0][7:0] bytes;
    job_cnt_t                 count;
    logic                     last;
  } job_t;

  localparam logic [7:0] AmpChar = 8'h26;

  localparam logic [7:0] EntText [NumEnt][JobBytes] = '{
    '{8'h26, 8'h61, 8'h6d, 8'h70, 8'h3b},
    '{8'h26, 8'h78, 8'h32, 8'h32, 8'h3b},
    '{8'h26, 8'h6c, 8'h74, 8'h3b, 8'h00},
    '{8'h26, 8'h67, 8'h74, 8'h3b, 8'h00}
  };

  localparam job_cnt_t EntLen [NumEnt] = '{3'd5, 3'd5, 3'd4, 3'd4};

  localparam logic [7:0] EntChar [NumEnt] = '{8'h26, 8'h22, 8'h3c, 8'h3e};

endpackage

FILE: rtl/core/xec_front.sv
// xec_front: direction register, partial entity hold and request classification
// depends on xec_pkg
module xec_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  input  logic          accept_i,
  input  xec_pkg::in_t  in_data_i,
  output xec_pkg::job_t job_o
);

  logic                            dir_q, dir_d;
  logic [2:0]                      hc_q, hc_d;
  logic [xec_pkg::HoldMax-1:0][7:0] held_q;
  logic                            held_we;
  logic [1:0]                      held_wa;
  logic [7:0]                      b;
  logic                            eos;
  logic [2:0]                      len;
  logic [xec_pkg::NumEnt-1:0]      match;
  logic                            done, prefix, esc_hit;
  logic [7:0]                      done_char;
  logic [1:0]                      esc_k;

  assign b   = in_data_i.in_byte;
  assign eos = in_data_i.end_of_string;
  assign len = 3'(hc_q + 3'd1);

  always_comb begin
    for (int k = 0; k < xec_pkg::NumEnt; k++) begin
      match[k] = (len <= xec_pkg::EntLen[k]) && (b == xec_pkg::EntText[k][hc_q]);
      for (int i = 0; i < xec_pkg::HoldMax; i++) begin
        if (3'(i) < hc_q && held_q[i] != xec_pkg::EntText[k][i]) begin
          match[k] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    done      = 1'b0;
    prefix    = 1'b0;
    done_char = b;
    esc_hit   = 1'b0;
    esc_k     = '0;
    for (int k = 0; k < xec_pkg::NumEnt; k++) begin
      if (match[k] && len == xec_pkg::EntLen[k]) begin
        done      = 1'b1;
        done_char = xec_pkg::EntChar[k];
      end
      if (match[k] && len < xec_pkg::EntLen[k]) begin
        prefix = 1'b1;
      end
      if (b == xec_pkg::EntChar[k]) begin
        esc_hit = 1'b1;
        esc_k   = 2'(k);
      end
    end
  end

  always_comb begin
    dir_d   = dir_q;
    hc_d    = hc_q;
    held_we = 1'b0;
    held_wa = '0;
    job_o.last  = eos;
    job_o.count = 3'd1;
    for (int i = 0; i < xec_pkg::HoldMax; i++) begin
      job_o.bytes[i] = (3'(i) < hc_q) ? held_q[i] : b;
    end
    job_o.bytes[xec_pkg::JobBytes-1] = b;

    if (!dir_q) begin
      if (esc_hit) begin
        job_o.count = xec_pkg::EntLen[esc_k];
        for (int i = 0; i < xec_pkg::JobBytes; i++) begin
          job_o.bytes[i] = xec_pkg::EntText[esc_k][i];
        end
      end
    end else if (done) begin
      job_o.bytes[0] = done_char;
      if (accept_i) begin
        hc_d = '0;
      end
    end else if (prefix && !eos && hc_q < 3'(xec_pkg::HoldMax)) begin
      job_o.count = '0;
      if (accept_i) begin
        held_we = 1'b1;
        held_wa = hc_q[1:0];
        hc_d    = len;
      end
    end else if (b == xec_pkg::AmpChar && !eos) begin
      // flush what is held and start a fresh entity
      job_o.count = hc_q;
      if (accept_i) begin
        held_we = 1'b1;
        held_wa = '0;
        hc_d    = 3'd1;
      end
    end else begin
      job_o.count = len;
      if (accept_i) begin
        hc_d = '0;
      end
    end

    if (cfg_we_i) begin
      dir_d = cfg_wdata_i;
      hc_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= 1'b0;
      hc_q  <= '0;
    end else begin
      dir_q <= dir_d;
      hc_q  <= hc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (held_we) begin
      held_q[held_wa] <= b;
    end
  end

endmodule

FILE: rtl/core/xec_queue.sv
// xec_queue: short job queue between the classifier and the byte serializer
// depends on xec_pkg
module xec_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  xec_pkg::job_t push_data_i,
  input  logic          pop_i,
  output xec_pkg::job_t head_o,
  output logic          empty_o,
  output logic          full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  xec_pkg::job_t   mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(Depth));
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(wr_q + 1'b1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : PtrW'(rd_q + 1'b1);
    end
    if (push_i && !pop_i) begin
      cnt_d = CntW'(cnt_q + 1'b1);
    end else if (pop_i && !push_i) begin
      cnt_d = CntW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count above depth");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");
  a_cnt_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> cnt_q == CntW'($past(cnt_q) + 1'b1))
    else $error("queue count did not follow push");
`endif

endmodule

FILE: rtl/core/xec_back.sv
// xec_back: walks the head job one byte per cycle, while the output is not stalled, into the output register
// depends on xec_pkg
module xec_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  xec_pkg::job_t head_i,
  input  logic          head_valid_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output xec_pkg::out_t out_data_o
);

  logic          out_valid_q, out_valid_d;
  xec_pkg::out_t out_q;
  logic [2:0]    idx_q, idx_d;
  logic          load, at_end;

  assign load   = head_valid_i && (!out_valid_q || !out_stall_i);
  assign at_end = (3'(idx_q + 3'd1) == head_i.count);
  assign pop_o  = load && at_end;

  always_comb begin
    out_valid_d = out_valid_q;
    idx_d       = idx_q;
    if (load) begin
      out_valid_d = 1'b1;
      idx_d       = at_end ? '0 : 3'(idx_q + 3'd1);
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.out_byte <= head_i.bytes[idx_q];
      out_q.out_last <= head_i.last && at_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/core/xml_entity_codec.sv
// xml_entity_codec: top level of the byte stream entity escape/unescape codec
// depends on xec_pkg, xec_front, xec_queue, xec_back
//
// One input byte is taken per cycle while the job queue (QueueDepth entries) has room;
// each request turns into 0 to 5 output bytes (1, 4 or 5 when escaping, 0 to 5 when
// decoding), and the output side sends one byte per cycle while out_stall_i is low, so
// plain text flows at one byte per cycle when neither side stalls. The first byte of a
// request passes through the job queue and then the output register before it appears.
// Direction writes drop any partially received entity.
module xml_entity_codec #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  xec_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output xec_pkg::out_t out_data_o
);

  xec_pkg::job_t job, head;
  logic          accept, push, pop, q_empty, q_full;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;
  assign push       = accept && (job.count != '0);

  xec_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .in_data_i   (in_data_i),
    .job_o       (job)
  );

  xec_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (job),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  xec_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (!q_empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

FILE: tb/xec_checker.sv
// xec_checker: entity reference tables for the testbench, and a checker that watches the codec's
// ports, predicts every output byte and compares it; depends on xec_pkg
package xec_tb_pkg;

  typedef enum logic {
    DirEscape   = 1'b0,
    DirUnescape = 1'b1
  } dir_e;

  localparam logic [7:0] ChAmp = 8'h26;
  localparam int unsigned NumRefs = 4;

  localparam logic [7:0] RefText [NumRefs][5] = '{
    '{8'h26, 8'h61, 8'h6d, 8'h70, 8'h3b},
    '{8'h26, 8'h78, 8'h32, 8'h32, 8'h3b},
    '{8'h26, 8'h6c, 8'h74, 8'h3b, 8'h00},
    '{8'h26, 8'h67, 8'h74, 8'h3b, 8'h00}
  };
  localparam int unsigned RefLen [NumRefs] = '{5, 5, 4, 4};
  localparam logic [7:0] RefChar [NumRefs] = '{8'h26, 8'h22, 8'h3c, 8'h3e};

endpackage

module xec_checker
  import xec_pkg::*;
  import xec_tb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_t         in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_t        out_data_i,
  output int unsigned error_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  dir_e        dir_q = DirEscape;
  logic [7:0]  held_q [4];
  int unsigned held_n = 0;
  out_t        expected_bytes [$];
  int unsigned errors = 0;

  function automatic void decode_request(input logic [7:0] b, input logic eos);
    logic [7:0]  emitted [5];
    int unsigned n_out;
    logic [7:0]  cand [5];
    int unsigned len;
    int          hit;
    logic        partial;
    logic        same;
    out_t        item;
    n_out   = 0;
    hit     = -1;
    partial = 1'b0;
    if (dir_q == DirEscape) begin
      for (int k = 0; k < NumRefs; k++) begin
        if (b == RefChar[k]) begin
          hit = k;
        end
      end
      if (hit >= 0) begin
        for (int i = 0; i < RefLen[hit]; i++) emitted[i] = RefText[hit][i];
        n_out = RefLen[hit];
      end else begin
        emitted[0] = b;
        n_out      = 1;
      end
    end else if (held_n == 0) begin
      if (b == ChAmp && !eos) begin
        held_q[0] = b;
        held_n    = 1;
      end else begin
        emitted[0] = b;
        n_out      = 1;
      end
    end else begin
      for (int i = 0; i < held_n; i++) cand[i] = held_q[i];
      cand[held_n] = b;
      len          = held_n + 1;
      for (int k = 0; k < NumRefs; k++) begin
        if (len <= RefLen[k]) begin
          same = 1'b1;
          for (int i = 0; i < len; i++) begin
            if (cand[i] != RefText[k][i]) same = 1'b0;
          end
          if (same && len == RefLen[k]) begin
            hit = k;
          end else if (same) begin
            partial = 1'b1;
          end
        end
      end
      if (hit >= 0) begin
        held_n     = 0;
        emitted[0] = RefChar[hit];
        n_out      = 1;
      end else if (partial && !eos && len <= 4) begin
        held_q[len-1] = b;
        held_n        = len;
      end else begin
        // no entity can match any more: held bytes go out as plain text
        for (int i = 0; i < held_n; i++) emitted[i] = held_q[i];
        n_out  = held_n;
        held_n = 0;
        if (b == ChAmp && !eos) begin
          held_q[0] = b;
          held_n    = 1;
        end else begin
          emitted[n_out] = b;
          n_out++;
        end
      end
    end
    for (int i = 0; i < n_out; i++) begin
      item.out_byte  = emitted[i];
      item.out_last  = eos && (i + 1 == n_out);
      expected_bytes = {expected_bytes, item};
    end
  endfunction

  function automatic void check_byte(input out_t got);
    out_t want;
    if (expected_bytes.size() == 0) begin
      $error("unexpected output: out_byte %h out_last %b", got.out_byte, got.out_last);
      errors++;
    end else begin
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %h, actual %h", want.out_byte, got.out_byte);
        errors++;
      end
      if (got.out_last !== want.out_last) begin
        $error("out_last: expected %b, actual %b", want.out_last, got.out_last);
        errors++;
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q  = DirEscape;
      held_n = 0;
      errors = 0;
      expected_bytes.delete();
      error_count_o <= 0;
      pending_o     <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_byte(out_data_i);
      if (cfg_we_i) begin
        dir_q  = dir_e'(cfg_wdata_i);
        held_n = 0;
      end
      if (in_valid_i && !in_stall_i) begin
        decode_request(in_data_i.in_byte, in_data_i.end_of_string);
      end
      error_count_o <= errors;
      pending_o     <= expected_bytes.size();
    end
  end

endmodule

FILE: tb/tb_top.sv
// tb_top: stimulus and verdict for xml_entity_codec, directed then random byte streams
// in both directions; depends on xec_pkg, xec_tb_pkg and xec_checker
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import xec_pkg::*;
  import xec_tb_pkg::*;

  // several times the longest legal quiet stretch (drain pad, idle gaps, stalls)
  localparam int unsigned WatchLimit = 2000;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic        cfg_wdata_i = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        out_stall_i = 1'b0;
  in_t         in_data_i   = '0;
  logic        in_stall_o;
  logic        out_valid_o;
  out_t        out_data_o;
  int unsigned error_count;
  int unsigned pending;
  logic        idle_en      = 1'b1;
  int unsigned stuck_cycles = 0;

  xml_entity_codec DUT (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_stall_o,
    .in_data_i,
    .out_valid_o,
    .out_stall_i,
    .out_data_o
  );

  xec_checker u_checker (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_stall_i    (in_stall_o),
    .in_data_i,
    .out_valid_i   (out_valid_o),
    .out_stall_i,
    .out_data_i    (out_data_o),
    .error_count_o (error_count),
    .pending_o     (pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= idle_en && ($urandom_range(99) < 6);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    wait (stuck_cycles >= WatchLimit);
    $display("status: fail");
    $finish;
  end

  task automatic send(input logic [7:0] b, input logic eos);
    if (idle_en && $urandom_range(99) < 6) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{in_byte: b, end_of_string: eos};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_text(input string s, input logic eos_at_end);
    for (int i = 0; i < s.len(); i++) send(s[i], eos_at_end && (i == s.len() - 1));
  endtask

  // hold off until every predicted byte is out, then let a held entity settle
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic set_direction(input dir_e d);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= d;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic run_phase(input dir_e d, input int unsigned n_items, input bit pause_mid);
    logic [7:0]  token [5];
    int unsigned n_tok;
    int unsigned cut;
    int unsigned sent;
    int unsigned pick;
    int unsigned k;
    sent = 0;
    drain();
    set_direction(d);
    while (sent < n_items) begin
      n_tok = 0;
      pick  = $urandom_range(99);
      k     = $urandom_range(NumRefs - 1);
      if (d == DirEscape) begin
        token[0] = pick < 30 ? RefChar[k] : 8'($urandom_range(255));
        n_tok    = 1;
      end else if (pick < 55) begin
        for (int i = 0; i < RefLen[k]; i++) token[i] = RefText[k][i];
        n_tok = RefLen[k];
      end else if (pick < 70) begin
        // cut-off entity, usually broken by whatever follows
        cut = $urandom_range(RefLen[k] - 1, 1);
        for (int i = 0; i < cut; i++) token[i] = RefText[k][i];
        n_tok = cut;
      end else if (pick < 85) begin
        token[0] = $urandom_range(1) ? RefChar[k] : RefText[k][$urandom_range(RefLen[k] - 1)];
        n_tok    = 1;
      end else begin
        token[0] = 8'($urandom_range(255));
        n_tok    = 1;
      end
      for (int i = 0; i < n_tok; i++) begin
        send(token[i], $urandom_range(11) == 0);
        sent++;
      end
      if (pause_mid && sent >= n_items / 2) begin
        drain();
        pause_mid = 1'b0;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_direction(DirEscape);
    send(8'h00, 1'b0);
    send_text("&\"<>", 1'b0);
    send(8'hff, 1'b1);

    drain();
    set_direction(DirUnescape);
    send_text("&lt&amp;", 1'b0);
    send_text("&x22;", 1'b1);
    send_text("&q", 1'b1);
    send_text("&", 1'b1);
    send_text("&l", 1'b0);
    drain();
    set_direction(DirUnescape);
    send_text("t;", 1'b1);

    run_phase(DirEscape, 35, 1'b0);
    run_phase(DirUnescape, 45, 1'b1);
    idle_en <= 1'b0;
    run_phase(DirUnescape, 45, 1'b0);
    idle_en <= 1'b1;
    run_phase(DirEscape, 25, 1'b0);
    run_phase(DirUnescape, 45, 1'b0);

    drain();
    if (error_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
